// ----- src/bed_pkg.sv -----
// Package with shared types and command codes for the bounded edit distance engine.
package bed_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FEED   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned VAL_W  = 7;
  localparam logic [VAL_W-1:0] THR_LIMIT = 7'd126;
  localparam logic [VAL_W-1:0] VAL_MAX   = 7'd127;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic             is_end;
    logic [CP_W-1:0]  cp;
    logic [VAL_W-1:0] new_val;
    logic [VAL_W-1:0] old_val;
  } tok_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic [VAL_W-1:0] cap;
    logic             rearm;
    logic             wr_en;
    logic [CP_W-1:0]  wr_cp;
  } ctrl_t;

  // Result offered by a cell when an end request reaches the last stored position.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] distance;
    logic             exceeded;
  } emit_t;

endpackage

// ----- src/bounded_edit_distance.sv -----
// Top level of the bounded edit distance engine: head cell, cell row and register port.
//
// Channel   Direction  Handshake               Payload
// input     in         start, busy             in_command, in_codepoint
// result    out        out_valid (strobe)      out_distance, out_exceeded, out_first_overflow
// config    in/out     psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// Feed and end requests are taken in every cycle while busy is low; each travels
// one cell per cycle. An end request's result is registered from the cell at the last
// stored position, or from the head cell when nothing is stored.
// Clear and append wait until the row has drained, then rearm all cells in one cycle.
// Busy stays high from a clear or append until it has been applied.
// Reset is synchronous and active low; the receiver of results cannot stall.
module bounded_edit_distance #(
  parameter int unsigned MAX_FIRST_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [bed_pkg::CP_W-1:0]     in_codepoint,
  output logic                         out_valid,
  output logic [bed_pkg::VAL_W-1:0]    out_distance,
  output logic                         out_exceeded,
  output logic                         out_first_overflow,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned LEN_W = $clog2(MAX_FIRST_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FIRST_LEN);

  logic [bed_pkg::VAL_W-1:0] maxd_r, maxd_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      pend_r, pend_nxt;
  logic                      pend_app_r, pend_app_nxt;
  logic [bed_pkg::CP_W-1:0]  pend_cp_r, pend_cp_nxt;
  logic [bed_pkg::VAL_W-1:0] r0_r, r0_nxt;
  bed_pkg::tok_t             tok0_r, tok0_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [bed_pkg::VAL_W-1:0] out_distance_r, out_distance_nxt;
  logic                      out_exceeded_r, out_exceeded_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      accept;
  logic                      cfg_wr;
  logic                      chain_busy;
  logic                      apply;
  logic [bed_pkg::VAL_W-1:0] thr, cap;
  logic [bed_pkg::VAL_W:0]   r0_inc;
  logic [bed_pkg::VAL_W-1:0] r0_feed;
  bed_pkg::cmd_t             cmd;
  bed_pkg::ctrl_t            ctrl;
  bed_pkg::emit_t            head_emit;
  bed_pkg::emit_t            emits [MAX_FIRST_LEN:0];
  logic [MAX_FIRST_LEN:0]    emit_vec;
  logic [MAX_FIRST_LEN:0]    tok_valid_vec;
  bed_pkg::tok_t             toks [MAX_FIRST_LEN:0];

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cmd    = bed_pkg::cmd_t'(in_command);
  assign pready = 1'b1;
  assign prdata = {25'd0, maxd_r};
  assign busy   = pend_r;

  always_comb begin
    thr     = (maxd_r > bed_pkg::THR_LIMIT) ? bed_pkg::THR_LIMIT : maxd_r;
    cap     = thr + 7'd1;
    r0_inc  = {1'b0, r0_r} + 8'd1;
    r0_feed = (r0_inc < {1'b0, cap}) ? r0_inc[bed_pkg::VAL_W-1:0] : cap;
  end

  assign toks[0] = tok0_r;

  genvar gi;
  generate
    for (gi = 1; gi <= MAX_FIRST_LEN; gi++) begin : g_cell
      bed_cell #(
        .IDX   (gi),
        .LEN_W (LEN_W)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .len     (len_r),
        .tok_in  (toks[gi-1]),
        .tok_out (toks[gi]),
        .emit    (emits[gi])
      );
    end
  endgenerate

  assign emits[0] = head_emit;

  always_comb begin
    for (int i = 0; i <= MAX_FIRST_LEN; i++) begin
      emit_vec[i]      = emits[i].valid;
      tok_valid_vec[i] = toks[i].valid;
    end
  end

  assign chain_busy = |tok_valid_vec;
  assign apply      = pend_r && !chain_busy;

  always_comb begin
    ctrl.cap   = cap;
    ctrl.rearm = apply;
    ctrl.wr_en = apply && pend_app_r && (len_r < LEN_MAX);
    ctrl.wr_cp = pend_cp_r;
  end

  always_comb begin
    head_emit.valid    = accept && (cmd == bed_pkg::CMD_END) && (len_r == '0);
    head_emit.distance = (r0_r < cap) ? r0_r : cap;
    head_emit.exceeded = (r0_r >= cap);
  end

  // Request handling at the head of the row.
  always_comb begin
    r0_nxt         = r0_r;
    tok0_nxt       = tok0_r;
    tok0_nxt.valid = 1'b0;
    pend_nxt       = pend_r;
    pend_app_nxt   = pend_app_r;
    pend_cp_nxt    = pend_cp_r;
    if (accept) begin
      case (cmd)
        bed_pkg::CMD_CLEAR: begin
          pend_nxt     = 1'b1;
          pend_app_nxt = 1'b0;
        end
        bed_pkg::CMD_APPEND: begin
          pend_nxt     = 1'b1;
          pend_app_nxt = 1'b1;
          pend_cp_nxt  = in_codepoint;
        end
        bed_pkg::CMD_FEED: begin
          tok0_nxt.valid   = 1'b1;
          tok0_nxt.is_end  = 1'b0;
          tok0_nxt.cp      = in_codepoint;
          tok0_nxt.new_val = r0_feed;
          tok0_nxt.old_val = r0_r;
          r0_nxt           = r0_feed;
        end
        bed_pkg::CMD_END: begin
          tok0_nxt.valid  = 1'b1;
          tok0_nxt.is_end = 1'b1;
          r0_nxt          = '0;
        end
        default: begin
          tok0_nxt.valid = 1'b0;
        end
      endcase
    end
    if (apply) begin
      pend_nxt = 1'b0;
      r0_nxt   = '0;
    end
  end

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (apply) begin
      if (!pend_app_r) begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (len_r < LEN_MAX) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    maxd_nxt = maxd_r;
    if (cfg_wr && (paddr == 2'd0)) begin
      maxd_nxt = pwdata[bed_pkg::VAL_W-1:0];
    end
  end

  // At most one source offers a result in a cycle, so the payload is an OR over all sources.
  always_comb begin
    out_valid_nxt    = |emit_vec;
    out_distance_nxt = '0;
    out_exceeded_nxt = 1'b0;
    for (int i = 0; i <= MAX_FIRST_LEN; i++) begin
      out_distance_nxt = out_distance_nxt | (emits[i].valid ? emits[i].distance : '0);
      out_exceeded_nxt = out_exceeded_nxt | (emits[i].valid && emits[i].exceeded);
    end
    out_ovf_nxt = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r       <= 7'd2;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      pend_r       <= 1'b0;
      pend_app_r   <= 1'b0;
      r0_r         <= '0;
      tok0_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      maxd_r       <= maxd_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      pend_r       <= pend_nxt;
      pend_app_r   <= pend_app_nxt;
      r0_r         <= r0_nxt;
      tok0_r.valid <= tok0_nxt.valid;
      out_valid_r  <= out_valid_nxt;
    end
    tok0_r.is_end  <= tok0_nxt.is_end;
    tok0_r.cp      <= tok0_nxt.cp;
    tok0_r.new_val <= tok0_nxt.new_val;
    tok0_r.old_val <= tok0_nxt.old_val;
  end

  always_ff @(posedge clk) begin
    pend_cp_r      <= pend_cp_nxt;
    out_distance_r <= out_distance_nxt;
    out_exceeded_r <= out_exceeded_nxt;
    out_ovf_r      <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_distance       = out_distance_r;
  assign out_exceeded       = out_exceeded_r;
  assign out_first_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // Only one position of the row may report an end request in any cycle.
  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(emit_vec))
    else $error("more than one cell reports a result");

  // A waiting clear or append is applied as soon as the row has drained.
  a_apply_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !chain_busy) |=> !pend_r)
    else $error("pending load request was not applied");

  // The overflow flag is set only once storage is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LEN_MAX))
    else $error("overflow flag set while storage not full");

  // The stored length never exceeds the storage depth.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("stored length out of range");
`endif

endmodule

// ----- src/bed_cell.sv -----
// One cell of the edit distance row: one stored codepoint and one row value.
module bed_cell #(
  parameter int unsigned IDX   = 1,
  parameter int unsigned LEN_W = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bed_pkg::ctrl_t      ctrl,
  input  logic [LEN_W-1:0]    len,
  input  bed_pkg::tok_t       tok_in,
  output bed_pkg::tok_t       tok_out,
  output bed_pkg::emit_t      emit
);

  localparam int unsigned J_INT = (IDX > 127) ? 127 : IDX;
  localparam logic [bed_pkg::VAL_W-1:0] REARM_VAL = bed_pkg::VAL_W'(J_INT);
  localparam logic [LEN_W-1:0] MY_LEN  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] MY_SLOT = LEN_W'(IDX - 1);

  logic [bed_pkg::CP_W-1:0]  char_r, char_nxt;
  logic [bed_pkg::VAL_W-1:0] row_r, row_nxt;
  bed_pkg::tok_t             tok_r, tok_nxt;

  logic                      cost;
  logic [bed_pkg::VAL_W:0]   s_ins, s_del, s_rep, m1, m2, best;
  logic [bed_pkg::VAL_W:0]   cap_w;
  logic [bed_pkg::VAL_W-1:0] new_val;

  always_comb begin
    cost  = (char_r != tok_in.cp);
    cap_w = {1'b0, ctrl.cap};
    s_ins = {1'b0, row_r} + 8'd1;
    s_del = {1'b0, tok_in.new_val} + 8'd1;
    s_rep = {1'b0, tok_in.old_val} + {7'd0, cost};
    m1    = (s_ins < s_del) ? s_ins : s_del;
    m2    = (m1 < s_rep) ? m1 : s_rep;
    best  = (m2 < cap_w) ? m2 : cap_w;
    new_val = best[bed_pkg::VAL_W-1:0];
  end

  always_comb begin
    row_nxt = row_r;
    if (ctrl.rearm) begin
      row_nxt = REARM_VAL;
    end else if (tok_in.valid) begin
      row_nxt = tok_in.is_end ? REARM_VAL : new_val;
    end
  end

  always_comb begin
    char_nxt = char_r;
    if (ctrl.wr_en && (len == MY_SLOT)) begin
      char_nxt = ctrl.wr_cp;
    end
  end

  always_comb begin
    tok_nxt         = tok_in;
    tok_nxt.new_val = new_val;
    tok_nxt.old_val = row_r;
  end

  always_comb begin
    emit.valid    = tok_in.valid && tok_in.is_end && (len == MY_LEN);
    emit.distance = (row_r < ctrl.cap) ? row_r : ctrl.cap;
    emit.exceeded = (row_r >= ctrl.cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= REARM_VAL;
      tok_r.valid <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.is_end   <= tok_nxt.is_end;
    tok_r.cp       <= tok_nxt.cp;
    tok_r.new_val  <= tok_nxt.new_val;
    tok_r.old_val  <= tok_nxt.old_val;
  end

  always_ff @(posedge clk) begin
    char_r         <= char_nxt;
  end

  assign tok_out = tok_r;

endmodule
